@@ sv/fnv1a64_preimage_meet_in_middle_defines.svh @@
// Assertion macros for the FNV-1a 64 preimage search block.
// Included by the RTL files that carry concurrent assertions.
`ifndef FNV1A64_PREIMAGE_MEET_IN_MIDDLE_DEFINES_SVH
`define FNV1A64_PREIMAGE_MEET_IN_MIDDLE_DEFINES_SVH
`ifndef SYNTHESIS
`define FNVMIM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fnvmim assertion failed");
`define FNVMIM_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("fnvmim assertion failed");
`else
`define FNVMIM_ASSERT(lbl, clk, rstn, prop)
`define FNVMIM_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

@@ sv/fnvmim_pkg.sv @@
// Package for the FNV-1a 64 preimage search: constants, types and the prime step.
// No dependencies.
`timescale 1ns / 1ps
package fnvmim_pkg;
  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrimeInv = 64'hCE965057AFF6957B;
  localparam int unsigned MaxMatchesDef = 4;
  localparam int unsigned AddrW = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_FWD1,
    ST_FWD2,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic build_step;
    logic fwd1;
    logic fwd2;
    logic scan_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic build_last;
    logic scan_last;
    logic table_ready;
    logic out_free;
    logic emit_last;
  } status_t;

  // Multiply by the FNV prime 2^40 + 0x1B3.
  function automatic logic [63:0] mul_prime(input logic [63:0] x);
    mul_prime = (x << 40) + (x * 64'h1B3);
  endfunction
endpackage

@@ sv/fnvmim_if.sv @@
// Stream interfaces for the search block: input items and result items.
// Depends on nothing.
`timescale 1ns / 1ps
interface fnvmim_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] high_half;
  modport source (output valid, kind, high_half, input ready);
  modport sink (input valid, kind, high_half, output ready);
endinterface

interface fnvmim_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        found;
  logic        overflow;
  logic        last;
  modport source (output valid, value, found, overflow, last, input ready);
  modport sink (input valid, value, found, overflow, last, output ready);
endinterface

@@ sv/fnvmim_ctrl.sv @@
// Sequencer of the search block: steps build, forward fold, scan and emission.
// Depends on fnvmim_pkg.
`timescale 1ns / 1ps
module fnvmim_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_kind_i,
  output logic                in_ready_o,
  input  fnvmim_pkg::status_t st_i,
  output fnvmim_pkg::cmd_t    cmd_o
);
  fnvmim_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fnvmim_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fnvmim_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!in_kind_i) begin
            state_d = fnvmim_pkg::ST_BUILD;
          end else if (st_i.table_ready) begin
            state_d = fnvmim_pkg::ST_FWD1;
          end else begin
            state_d = fnvmim_pkg::ST_EMIT;
          end
        end
      end
      fnvmim_pkg::ST_BUILD: begin
        if (st_i.build_last) state_d = fnvmim_pkg::ST_EMIT;
      end
      fnvmim_pkg::ST_FWD1: state_d = fnvmim_pkg::ST_FWD2;
      fnvmim_pkg::ST_FWD2: state_d = fnvmim_pkg::ST_SCAN;
      fnvmim_pkg::ST_SCAN: begin
        if (st_i.scan_last) state_d = fnvmim_pkg::ST_EMIT;
      end
      fnvmim_pkg::ST_EMIT: begin
        if (st_i.out_free && st_i.emit_last) state_d = fnvmim_pkg::ST_IDLE;
      end
      default: state_d = fnvmim_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      fnvmim_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      fnvmim_pkg::ST_BUILD: cmd_o.build_step = 1'b1;
      fnvmim_pkg::ST_FWD1: cmd_o.fwd1 = 1'b1;
      fnvmim_pkg::ST_FWD2: cmd_o.fwd2 = 1'b1;
      fnvmim_pkg::ST_SCAN: cmd_o.scan_step = 1'b1;
      fnvmim_pkg::ST_EMIT: cmd_o.emit = st_i.out_free;
      default: cmd_o = '0;
    endcase
  end
endmodule

@@ sv/fnvmim_dp.sv @@
// Datapath of the search block: inverse product, forward fold, match scan,
// hit buffer and result register. Depends on fnvmim_pkg, fnvmim_if and the defines.
`timescale 1ns / 1ps
`include "fnv1a64_preimage_meet_in_middle_defines.svh"
module fnvmim_dp #(
  parameter int unsigned MAX_MATCHES = fnvmim_pkg::MaxMatchesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fnvmim_pkg::cmd_t    cmd_i,
  output fnvmim_pkg::status_t st_o,
  input  logic                in_kind_i,
  input  logic [15:0]         in_high_half_i,
  input  logic [63:0]         start_state_i,
  input  logic [63:0]         target_hash_i,
  fnvmim_out_if.source        out_o
);
  localparam int unsigned NW = $clog2(MAX_MATCHES + 1);
  localparam int unsigned IW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
  localparam logic [NW-1:0] NMax = NW'(MAX_MATCHES);

  logic [63:0] acc_q, acc_d, mcnd_q, mcnd_d, fwd_q, fwd_d;
  logic [5:0]  bit_q, bit_d;
  logic [7:0]  b1_q, b1_d;
  logic [15:0] hi_q;
  logic        ready_q, ready_d, ovf_q, ovf_d;
  logic [NW-1:0] n_q, n_d, e_q, e_d;
  logic [15:0] hits_q [MAX_MATCHES];
  logic [63:0] cand, diff;
  logic        hit;
  logic        oval_q, oval_d, ofound_q, oovf_q, olast_q;
  logic [31:0] ovalue_q;

  // The backward state at b0 equals the forward state exactly when
  // (fwd ^ b1) * prime ^ (target * prime_inv) leaves only its low byte set.
  assign cand = fnvmim_pkg::mul_prime(fwd_q ^ {56'd0, b1_q});
  assign diff = cand ^ acc_q;
  assign hit  = (diff[63:8] == 56'd0);

  always_comb begin
    acc_d = acc_q; mcnd_d = mcnd_q; bit_d = bit_q; ready_d = ready_q;
    fwd_d = fwd_q; b1_d = b1_q; n_d = n_q; ovf_d = ovf_q; e_d = e_q;
    if (cmd_i.accept) begin
      n_d = '0; ovf_d = 1'b0; e_d = '0; b1_d = '0;
      if (!in_kind_i) begin
        acc_d = '0; mcnd_d = target_hash_i; bit_d = '0; ready_d = 1'b0;
      end
    end
    if (cmd_i.build_step) begin
      if (fnvmim_pkg::FnvPrimeInv[bit_q]) acc_d = acc_q + mcnd_q;
      mcnd_d = mcnd_q << 1;
      bit_d = bit_q + 6'd1;
      if (bit_q == 6'd63) ready_d = 1'b1;
    end
    if (cmd_i.fwd1) fwd_d = fnvmim_pkg::mul_prime(start_state_i ^ {56'd0, hi_q[15:8]});
    if (cmd_i.fwd2) fwd_d = fnvmim_pkg::mul_prime(fwd_q ^ {56'd0, hi_q[7:0]});
    if (cmd_i.scan_step) begin
      b1_d = b1_q + 8'd1;
      if (hit) begin
        if (n_q < NMax) n_d = n_q + NW'(1);
        else ovf_d = 1'b1;
      end
    end
    if (cmd_i.emit) e_d = e_q + NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      bit_q   <= '0;
      b1_q    <= '0;
      n_q     <= '0;
      e_q     <= '0;
      ovf_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      ready_q <= ready_d;
      bit_q   <= bit_d;
      b1_q    <= b1_d;
      n_q     <= n_d;
      e_q     <= e_d;
      ovf_q   <= ovf_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    mcnd_q <= mcnd_d;
    fwd_q  <= fwd_d;
    if (cmd_i.accept) hi_q <= in_high_half_i;
    if (cmd_i.scan_step && hit && (n_q < NMax)) begin
      hits_q[n_q[IW-1:0]] <= {b1_q, diff[7:0]};
    end
    if (cmd_i.emit) begin
      if (n_q == '0) begin
        ovalue_q <= '0; ofound_q <= 1'b0; oovf_q <= 1'b0; olast_q <= 1'b1;
      end else begin
        ovalue_q <= {hi_q, hits_q[e_q[IW-1:0]]};
        ofound_q <= 1'b1;
        oovf_q   <= ovf_q;
        olast_q  <= st_o.emit_last;
      end
    end
  end

  always_comb begin
    oval_d = oval_q;
    if (out_o.ready) oval_d = 1'b0;
    if (cmd_i.emit) oval_d = 1'b1;
  end

  assign out_o.valid    = oval_q;
  assign out_o.value    = ovalue_q;
  assign out_o.found    = ofound_q;
  assign out_o.overflow = oovf_q;
  assign out_o.last     = olast_q;

  assign st_o.build_last  = (bit_q == 6'd63);
  assign st_o.scan_last   = (b1_q == 8'hFF);
  assign st_o.table_ready = ready_q;
  assign st_o.out_free    = !oval_q || out_o.ready;
  assign st_o.emit_last   = (n_q == '0) || ((e_q + NW'(1)) == n_q);

  `FNVMIM_ASSERT(a_ovf_full, clk_i, rst_ni, ovf_q |-> (n_q == NMax))
  `FNVMIM_ASSERT(a_n_bound, clk_i, rst_ni, n_q <= NMax)
  `FNVMIM_ASSERT(a_empty_zero, clk_i, rst_ni, (oval_q && !ofound_q) |-> (ovalue_q == '0 && olast_q))
  `FNVMIM_ASSERT_NXT(a_hit_count, clk_i, rst_ni, cmd_i.scan_step && hit && !ovf_q && n_q < NMax, n_q == $past(n_q) + NW'(1))
endmodule

@@ sv/fnv1a64_preimage_meet_in_middle.sv @@
// Top level of the FNV-1a 64 meet-in-the-middle preimage search.
// Depends on fnvmim_pkg, fnvmim_if, fnvmim_ctrl and fnvmim_dp.
//
//   channel  direction  handshake          payload
//   in_i     sink       valid/ready        kind, high_half
//   out_o    source     valid/ready        value, found, overflow, last
//   apb      slave      psel/penable       start_state @0x0, target_hash @0x8
//
// A build item runs a shift-add loop of 64 steps that forms target times the
// inverse prime. A probe item runs two fold steps and a scan of 256 upper low-half
// bytes, one per cycle, then emits the results.
// Reset leaves the table marked empty; no clearing pass is needed.
// A stalled output holds the result register; the block takes an item only when idle.
`timescale 1ns / 1ps
module fnv1a64_preimage_meet_in_middle #(
  parameter int unsigned MAX_MATCHES = fnvmim_pkg::MaxMatchesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fnvmim_in_if.sink                    in_i,
  fnvmim_out_if.source                 out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fnvmim_pkg::AddrW-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  logic [63:0] start_q, target_q;
  logic        wr;
  fnvmim_pkg::cmd_t    cmd;
  fnvmim_pkg::status_t st;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? target_q : start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= fnvmim_pkg::FnvBasis;
      target_q <= '0;
    end else if (wr) begin
      if (paddr[3]) target_q <= pwdata;
      else start_q <= pwdata;
    end
  end

  fnvmim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fnvmim_dp #(.MAX_MATCHES(MAX_MATCHES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .in_kind_i      (in_i.kind),
    .in_high_half_i (in_i.high_half),
    .start_state_i  (start_q),
    .target_hash_i  (target_q),
    .out_o          (out_o)
  );
endmodule

@@ verif/fnv1a64_preimage_meet_in_middle_checker.sv @@
// Checker for the FNV-1a 64 preimage search: it watches the APB port and both item
// channels, predicts the results of each accepted item and compares them.
// Depends on fnvmim_pkg and fnvmim_if.
`timescale 1ns / 1ps
module fnv1a64_preimage_meet_in_middle_checker #(
  parameter int unsigned MAX_MATCHES = fnvmim_pkg::MaxMatchesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fnvmim_in_if.sink                    in_mon,
  fnvmim_out_if.sink                   out_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fnvmim_pkg::AddrW-1:0] paddr,
  input  logic [63:0]                  pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending_count,
  output int                           result_count,
  output int                           match_count
);
  localparam logic [63:0] FnvPrime = 64'h100000001B3;
  localparam logic [fnvmim_pkg::AddrW-1:0] AddrStart = 4'h0;
  localparam logic [fnvmim_pkg::AddrW-1:0] AddrTarget = 4'h8;
  localparam logic KindBuild = 1'b0;

  typedef struct {
    logic [31:0] value;
    logic        found;
    logic        overflow;
    logic        last;
  } result_t;

  result_t     expected_results[$];
  logic [63:0] start_state;
  logic [63:0] target_hash;
  logic [63:0] table_target;
  logic        table_built;

  assign pending_count = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic [63:0] fold_byte(input logic [63:0] h, input logic [7:0] b);
    fold_byte = (h ^ {56'd0, b}) * FnvPrime;
  endfunction

  // The backward table holds, for each low half, the state that folds to the target.
  // Equality is checked forward: fold the low half from the probe state instead.
  task automatic predict_probe(input logic [15:0] hi);
    logic [63:0] fwd;
    logic [15:0] hits[$];
    logic        ovf;
    result_t     r;
    ovf = 1'b0;
    fwd = fold_byte(fold_byte(start_state, hi[15:8]), hi[7:0]);
    for (int lo = 0; lo < 65536; lo++) begin
      if (fold_byte(fold_byte(fwd, lo[15:8]), lo[7:0]) == table_target) begin
        if (hits.size() < MAX_MATCHES) hits.push_back(lo[15:0]);
        else ovf = 1'b1;
      end
    end
    if (hits.size() == 0) begin
      r = '{32'd0, 1'b0, 1'b0, 1'b1};
      expected_results.push_back(r);
    end else begin
      foreach (hits[k]) begin
        r = '{{hi, hits[k]}, 1'b1, ovf, k == hits.size() - 1};
        expected_results.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    if (!rst_ni) begin
      start_state <= fnvmim_pkg::FnvBasis;
      target_hash <= 64'd0;
      table_built <= 1'b0;
      table_target <= 64'd0;
      fail_count <= 0;
      result_count <= 0;
      match_count <= 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrStart) start_state <= pwdata;
        else if (paddr == AddrTarget) target_hash <= pwdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KindBuild) begin
          table_built <= 1'b1;
          table_target <= target_hash;
          r = '{32'd0, 1'b0, 1'b0, 1'b1};
          expected_results.push_back(r);
        end else if (!table_built) begin
          r = '{32'd0, 1'b0, 1'b0, 1'b1};
          expected_results.push_back(r);
        end else begin
          predict_probe(in_mon.high_half);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        result_count <= result_count + 1;
        if (out_mon.found) match_count <= match_count + 1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h", out_mon.value));
        end else begin
          r = expected_results.pop_front();
          if (out_mon.value !== r.value)
            report_mismatch($sformatf("value %h, wanted %h", out_mon.value, r.value));
          if (out_mon.found !== r.found)
            report_mismatch($sformatf("found %b, wanted %b", out_mon.found, r.found));
          if (out_mon.overflow !== r.overflow)
            report_mismatch($sformatf("overflow %b, wanted %b", out_mon.overflow,
                                      r.overflow));
          if (out_mon.last !== r.last)
            report_mismatch($sformatf("last %b, wanted %b", out_mon.last, r.last));
        end
      end
    end
  end
endmodule

@@ verif/fnv1a64_preimage_meet_in_middle_tb.sv @@
// Testbench top for the FNV-1a 64 preimage search: clock, reset, APB writes and
// item stimulus with random idling; the checker module predicts and compares.
// Depends on fnvmim_pkg, fnvmim_if, the block and its checker.
`timescale 1ns / 1ps
module fnv1a64_preimage_meet_in_middle_tb;
  localparam logic KindBuild = 1'b0;
  localparam logic KindProbe = 1'b1;
  localparam logic [fnvmim_pkg::AddrW-1:0] AddrStart = 4'h0;
  localparam logic [fnvmim_pkg::AddrW-1:0] AddrTarget = 4'h8;
  localparam logic [63:0] FnvPrime = 64'h100000001B3;
  localparam int WatchdogLimit = 20000;
  localparam int RandomItems = 440;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [fnvmim_pkg::AddrW-1:0] paddr;
  logic [63:0] pwdata, prdata;
  int fail_count, pending_count, result_count, match_count;
  int idle_cycles;
  int items_sent;
  logic sink_calm;

  fnvmim_in_if  in_ch ();
  fnvmim_out_if out_ch ();

  fnv1a64_preimage_meet_in_middle dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fnv1a64_preimage_meet_in_middle_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .match_count(match_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d results outstanding", pending_count);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side: ready stalls in random bursts unless calm.
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!sink_calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [fnvmim_pkg::AddrW-1:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic kind, input logic [15:0] hi, input bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.high_half <= hi;
    do @(posedge clk_i); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // Target reached from start through value v, so that v is a known solution.
  function automatic logic [63:0] hash_of(input logic [63:0] s, input logic [31:0] v);
    logic [63:0] h;
    h = s;
    for (int i = 3; i >= 0; i--) h = (h ^ {56'd0, v[8*i +: 8]}) * FnvPrime;
    return h;
  endfunction

  // A new start and target, built, with a planted solution.
  task automatic new_phase(input logic [63:0] s, input logic [31:0] v, input bit gaps);
    drain();
    write_reg(AddrStart, s);
    write_reg(AddrTarget, hash_of(s, v));
    send_item(KindBuild, 16'($urandom), gaps);
  endtask

  initial begin
    logic [31:0] planted;
    logic [63:0] s;
    rst_ni = 1'b0;
    sink_calm = 1'b0;
    items_sent = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KindBuild;
    in_ch.high_half = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(KindProbe, 16'hFFFF, 1'b0);
    send_item(KindBuild, 16'hFFFF, 1'b0);
    send_item(KindProbe, 16'h0000, 1'b0);
    send_item(KindProbe, 16'hFFFF, 1'b0);
    new_phase(64'd0, 32'h0000_0000, 1'b0);
    send_item(KindProbe, 16'h0000, 1'b0);
    new_phase(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(KindProbe, 16'hFFFF, 1'b0);
    send_item(KindProbe, 16'h5AA5, 1'b0);
    planted = 32'h1234_8001;
    new_phase(fnvmim_pkg::FnvBasis, planted, 1'b0);
    // Target changes after the build must not touch the table.
    drain();
    write_reg(AddrTarget, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KindProbe, planted[31:16], 1'b0);
    send_item(KindProbe, 16'hA55A, 1'b0);
    send_item(KindBuild, 16'h0000, 1'b0);
    send_item(KindProbe, 16'h0001, 1'b0);

    while (items_sent < RandomItems) begin
      s = {$urandom, $urandom};
      planted = $urandom;
      new_phase(s, planted, items_sent < RandomItems - 60);
      repeat ($urandom_range(10, 30)) begin
        case ($urandom_range(0, 9))
          0: send_item(KindBuild, 16'($urandom), items_sent < RandomItems - 60);
          1, 2, 3, 4: send_item(KindProbe, planted[31:16], items_sent < RandomItems - 60);
          default: send_item(KindProbe, 16'($urandom), items_sent < RandomItems - 60);
        endcase
        if (items_sent > RandomItems - 60) sink_calm = 1'b1;
      end
    end

    drain();
    $display("Sent %0d items over many start and target settings; %0d results, %0d matches.",
             items_sent, result_count, match_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
